@@ hw/rtl/dtq_pkg.sv @@
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int MS_PER_S = 1000;
    localparam logic [15:0] MAX_WAIT_RST = 16'd500;

    typedef enum logic [2:0] {
        F_CREATE   = 3'd0,
        F_DELETE   = 3'd1,
        F_ACTIVATE = 3'd2,
        F_PAUSE    = 3'd3,
        F_UNPAUSE  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_FULL        = 3'd2,
        ST_PAUSED      = 3'd3,
        ST_NOT_PAUSED  = 3'd4,
        ST_NOTHING_DUE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS,
        S_HEAD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [47:0] now_ms;
        logic [31:0] now_sec;
        logic [31:0] target_object;
        logic [31:0] target_message;
        logic [30:0] delay_ms;
        logic [31:0] which_timer;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] new_id;
        logic        fired;
        logic [31:0] fired_object;
        logic [31:0] fired_message;
        logic [31:0] fired_id;
        logic        new_head;
        logic [6:0]  active_count;
        logic [15:0] wait_ms;
    } t_res;

    typedef struct packed {
        logic [47:0] deadline;
        logic [31:0] object;
        logic [31:0] message;
        logic [31:0] id;
    } t_entry;

endpackage

@@ hw/rtl/deadline_timer_queue.sv @@
// Deadline-sorted one-shot timer queue with a one-read, one-write-port entry store.
// Pause, full create and idle ops go from accept straight to S_HEAD and S_FIN; delete,
// activate, unpause and create walk the sorted store one entry per cycle in S_WALK first,
// plus S_INS for a create that lands at the head. One request at a time: busy is high from
// accept until the result strobe. The result strobe o_valid lasts one cycle; the receiver
// cannot stall. Synchronous active-low reset empties the queue, clears pause, clamp = 500.
module deadline_timer_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  dtq_pkg::t_req   i_req,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    output logic            o_valid,
    output dtq_pkg::t_res   o_res
);
    import dtq_pkg::*;

    localparam logic [47:0] MAX48 = '1;

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    t_state      r_state, n_state;
    t_req        r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_next_id, n_next_id;
    logic        r_paused, n_paused;
    logic [31:0] r_paused_at, n_paused_at;
    logic [15:0] r_max_wait;
    logic [41:0] r_add, n_add;
    logic [47:0] r_dl, n_dl;
    logic [AW-1:0] r_ra, n_ra;
    logic [AW-1:0] r_ri, n_ri;
    logic        r_more, n_more;
    logic        r_rv, n_rv;
    logic        r_found, n_found;
    t_res        r_res, n_res;
    logic        r_valid, n_valid;

    t_entry      r_mem [CAPACITY];
    t_entry      r_rd;
    logic        we, re;
    logic [AW-1:0] wa, ra;
    t_entry      wd;

    logic        last;
    logic        match;
    logic [47:0] sum_dl;
    logic [47:0] diff;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_paused    = r_paused;
        n_paused_at = r_paused_at;
        n_add       = r_add;
        n_dl        = r_dl;
        n_ra        = r_ra;
        n_ri        = r_ri;
        n_more      = r_more;
        n_rv        = r_rv;
        n_found     = r_found;
        n_res       = r_res;
        n_valid     = 1'b0;
        we          = 1'b0;
        wa          = '0;
        wd          = '0;
        re          = 1'b0;
        ra          = r_ra;
        sum_dl      = sat48(i_req.now_ms, {17'd0, i_req.delay_ms});
        diff        = r_rd.deadline - r_req.now_ms;
        last        = (r_req.func == F_CREATE) ? (r_ra == '0)
                                               : (r_ra == AW'(r_count - CW'(1)));
        match       = (r_req.func == F_DELETE) ? (r_rd.id == r_req.which_timer)
                                               : (r_ri == '0 && r_req.now_ms > r_rd.deadline);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_res   = '0;
                    n_rv    = 1'b0;
                    n_found = 1'b0;
                    n_more  = 1'b1;
                    n_state = S_HEAD;
                    case (i_req.func) inside
                        F_CREATE: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_dl          = sum_dl;
                                n_res.new_id  = r_next_id;
                                n_next_id     = r_next_id + 32'd1;
                                n_count       = r_count + CW'(1);
                                if (r_count == '0) begin
                                    we = 1'b1;
                                    wd = '{sum_dl, i_req.target_object,
                                           i_req.target_message, r_next_id};
                                    n_res.new_head = 1'b1;
                                end else begin
                                    n_ra    = AW'(r_count - CW'(1));
                                    n_state = S_WALK;
                                end
                            end
                        end
                        F_DELETE, F_ACTIVATE: begin
                            if (r_count == '0) begin
                                n_res.status = (i_req.func == F_DELETE) ? ST_NOT_FOUND
                                                                        : ST_NOTHING_DUE;
                            end else begin
                                n_ra    = '0;
                                n_state = S_WALK;
                            end
                        end
                        F_PAUSE: begin
                            if (r_paused) begin
                                n_res.status = ST_PAUSED;
                            end else begin
                                n_paused    = 1'b1;
                                n_paused_at = i_req.now_sec;
                            end
                        end
                        F_UNPAUSE: begin
                            if (!r_paused) begin
                                n_res.status = ST_NOT_PAUSED;
                            end else begin
                                n_add       = (i_req.now_sec > r_paused_at) ?
                                              42'(i_req.now_sec - r_paused_at) *
                                              42'(MS_PER_S) : '0;
                                n_paused    = 1'b0;
                                n_paused_at = '0;
                                if (r_count != '0) begin
                                    n_ra    = '0;
                                    n_state = S_WALK;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                // issue the next read while the previous entry is processed
                if (r_more) begin
                    re   = 1'b1;
                    n_rv = 1'b1;
                    n_ri = r_ra;
                    if (last) begin
                        n_more = 1'b0;
                    end else if (r_req.func == F_CREATE) begin
                        n_ra = r_ra - AW'(1);
                    end else begin
                        n_ra = r_ra + AW'(1);
                    end
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    case (r_req.func)
                        F_CREATE: begin
                            we = 1'b1;
                            wa = r_ri + AW'(1);
                            if (r_rd.deadline > r_dl) begin
                                wd = r_rd;
                                if (r_ri == '0) begin
                                    n_res.new_head = 1'b1;
                                    n_state        = S_INS;
                                end
                            end else begin
                                wd      = '{r_dl, r_req.target_object,
                                            r_req.target_message, r_res.new_id};
                                n_state = S_HEAD;
                            end
                        end
                        F_UNPAUSE: begin
                            we = 1'b1;
                            wa = r_ri;
                            wd = r_rd;
                            wd.deadline = sat48(r_rd.deadline, {6'd0, r_add});
                            if (r_ri == AW'(r_count - CW'(1))) n_state = S_HEAD;
                        end
                        default: begin
                            if (r_found) begin
                                we = 1'b1;
                                wa = r_ri - AW'(1);
                                wd = r_rd;
                            end else if (match) begin
                                n_found = 1'b1;
                                if (r_req.func == F_ACTIVATE) begin
                                    n_res.fired         = 1'b1;
                                    n_res.fired_object  = r_rd.object;
                                    n_res.fired_message = r_rd.message;
                                    n_res.fired_id      = r_rd.id;
                                end
                            end else if (r_req.func == F_ACTIVATE) begin
                                n_res.status = ST_NOTHING_DUE;
                                n_state      = S_HEAD;
                            end
                            if (r_ri == AW'(r_count - CW'(1)) && n_state == S_WALK) begin
                                n_state = S_HEAD;
                                if (r_found || match) n_count = r_count - CW'(1);
                                else n_res.status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
                if (n_state != S_WALK) begin
                    n_more = 1'b0;
                    n_rv   = 1'b0;
                end
            end
            S_INS: begin
                we      = 1'b1;
                wa      = '0;
                wd      = '{r_dl, r_req.target_object, r_req.target_message, r_res.new_id};
                n_state = S_HEAD;
            end
            S_HEAD: begin
                re      = 1'b1;
                ra      = '0;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_res.active_count = 7'(r_count);
                if (r_count == '0) begin
                    n_res.wait_ms = r_max_wait;
                end else if (r_rd.deadline > r_req.now_ms) begin
                    n_res.wait_ms = (diff > {32'd0, r_max_wait}) ? r_max_wait : diff[15:0];
                end else begin
                    n_res.wait_ms = '0;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_id   <= '0;
            r_paused    <= 1'b0;
            r_paused_at <= '0;
            r_max_wait  <= MAX_WAIT_RST;
            r_more      <= 1'b0;
            r_rv        <= 1'b0;
            r_found     <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_paused    <= n_paused;
            r_paused_at <= n_paused_at;
            if (i_cfg_we) r_max_wait <= i_cfg_wdata;
            r_more      <= n_more;
            r_rv        <= n_rv;
            r_found     <= n_found;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_add <= n_add;
        r_dl  <= n_dl;
        r_ra  <= n_ra;
        r_ri  <= n_ri;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (re) r_rd <= r_mem[ra];
    end

endmodule
